>>> hdl/greedy_box_nms_macros.svh
// Assertion macros used by the checker file of the box suppression block.
`ifndef GREEDY_BOX_NMS_MACROS_SVH
`define GREEDY_BOX_NMS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("greedy_box_nms check failed");

// Consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("greedy_box_nms check failed");

`endif

>>> hdl/gbn_pkg.sv
// Shared constants and types of the greedy box suppression block.
package gbn_pkg;
	localparam int MAX_KEEP_DEF   = 512;
	localparam int MAX_BOXES_DEF  = 8192;
	localparam int COORD_BITS_DEF = 18;

	localparam int THR_W      = 16;
	localparam int LIMIT_W    = 10;
	localparam int NUMBER_W   = 13;
	localparam int RANK_W     = 9;
	localparam int OUT_DATA_W = 24;
	localparam int ONE_PIXEL  = 16;
	localparam int Q_FRAC     = 16;

	localparam logic [THR_W-1:0]   THR_RESET   = 16'd45875;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd300;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	typedef enum logic [1:0] {ST_IDLE, ST_AREA, ST_SCAN, ST_FINISH} state_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
		logic res_sup;
	} iou_stat_t;
endpackage

>>> hdl/greedy_box_nms.sv
// Greedy non-maximum suppression over a score-sorted stream of boxes.
// Each box is compared against every box kept so far in the frame before the next ready.
// The overlap unit checks one kept box per cycle; a full keep list skips the scan, and a
// stalled result adds its stall. Reset clears the keep count, box counter and handshakes
// and loads the register defaults; the kept-box store needs no clearing pass.
module greedy_box_nms #(
	parameter int MAX_KEEP   = gbn_pkg::MAX_KEEP_DEF,
	parameter int MAX_BOXES  = gbn_pkg::MAX_BOXES_DEF,
	parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [gbn_pkg::THR_W-1:0]              cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// left_x, top_y, right_x, bottom_y from bit 0 up, zero padded
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	// frame_start
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// box_number, keep_rank from bit 0 up, zero padded
	output logic [gbn_pkg::OUT_DATA_W-1:0]         m_tdata,
	// kept, limit_reached from bit 0 up
	output logic [1:0]                             m_tuser
);
	import gbn_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int SW     = C + 2;
	localparam int AREA_W = 2*C + 4;
	localparam int RW     = 4*C + AREA_W;
	localparam int AW     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int KW     = $clog2(MAX_KEEP + 1);
	localparam int BW     = $clog2(MAX_BOXES);
	localparam int LW     = (KW > LIMIT_W) ? KW : LIMIT_W;

	state_t state_q, state_d;

	logic [THR_W-1:0]   thr_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [KW-1:0]      cnt_q, cnt_base, iss_q;
	logic [BW-1:0]      bc_q, bc_base, number_q;
	logic               full_q, sup_q, rd_v_q;
	logic [4*C-1:0]     box_q;
	logic signed [AREA_W-1:0] area_q;
	logic signed [SW-1:0] dx, dy;
	logic [LW-1:0]      lim;
	logic               accept, issue, out_load, keep_now, scan_done;
	logic [RW-1:0]      krec;
	iou_stat_t          stat;

	logic               m_tvalid_q, kept_q, lim_q;
	logic [RANK_W-1:0]  rank_q;
	logic [NUMBER_W-1:0] num_out_q;

	assign accept   = s_tvalid && s_tready;
	assign cnt_base = s_tuser ? '0 : cnt_q;
	assign bc_base  = s_tuser ? '0 : bc_q;
	assign lim      = (LW'(limit_q) > LW'(MAX_KEEP)) ? LW'(MAX_KEEP) : LW'(limit_q);
	assign keep_now = !full_q && !sup_q;
	assign dx       = SW'($signed(box_q[2*C +: C])) - SW'($signed(box_q[0*C +: C]))
	                  + SW'(ONE_PIXEL);
	assign dy       = SW'($signed(box_q[3*C +: C])) - SW'($signed(box_q[1*C +: C]))
	                  + SW'(ONE_PIXEL);
	assign scan_done = (iss_q == cnt_q) && !rd_v_q && !stat.busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_AREA;
			ST_AREA:   state_d = full_q ? ST_FINISH : ST_SCAN;
			ST_SCAN:   if (scan_done) state_d = ST_FINISH;
			ST_FINISH: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		issue    = (state_q == ST_SCAN) && (iss_q < cnt_q);
		out_load = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			thr_q      <= THR_RESET;
			limit_q    <= LIMIT_RESET;
			cnt_q      <= '0;
			bc_q       <= '0;
			iss_q      <= '0;
			full_q     <= 1'b0;
			sup_q      <= 1'b0;
			rd_v_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_q  <= issue;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_THRESHOLD: thr_q   <= cfg_data;
					REG_LIMIT:     limit_q <= cfg_data[LIMIT_W-1:0];
					default:       thr_q   <= thr_q;
				endcase
			end
			if (accept) begin
				cnt_q  <= cnt_base;
				bc_q   <= (bc_base < BW'(MAX_BOXES - 1)) ? bc_base + 1'b1 : bc_base;
				full_q <= (LW'(cnt_base) >= lim);
				sup_q  <= 1'b0;
				iss_q  <= '0;
			end
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			if (stat.res_valid && stat.res_sup) begin
				sup_q <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				if (keep_now) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q    <= s_tdata[4*C-1:0];
			number_q <= bc_base;
		end
		if (state_q == ST_AREA) begin
			area_q <= dx * dy;
		end
		if (out_load) begin
			kept_q    <= keep_now;
			lim_q     <= full_q;
			rank_q    <= keep_now ? RANK_W'(cnt_q) : '0;
			num_out_q <= NUMBER_W'(number_q);
		end
	end

	gbn_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_KEEP)
	) u_store (
		.clk   (clk),
		.we    (out_load && keep_now),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({area_q, box_q}),
		.re    (issue),
		.raddr (iss_q[AW-1:0]),
		.rdata (krec)
	);

	gbn_iou #(
		.COORD_BITS (COORD_BITS)
	) u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_v_q),
		.krec     (krec),
		.box      (box_q),
		.barea    (area_q),
		.thr      (thr_q),
		.stat     (stat)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-RANK_W-NUMBER_W){1'b0}}, rank_q, num_out_q};
	assign m_tuser  = {lim_q, kept_q};
endmodule

>>> hdl/gbn_ram.sv
// Generic simple dual-port RAM with registered read.
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> hdl/gbn_iou.sv
// Pipelined overlap unit: one kept box against the current box per cycle.
module gbn_iou #(
	parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [6*COORD_BITS+3:0]               krec,
	input  logic [4*COORD_BITS-1:0]               box,
	input  logic signed [2*COORD_BITS+3:0]        barea,
	input  logic [gbn_pkg::THR_W-1:0]             thr,
	output gbn_pkg::iou_stat_t                    stat
);
	import gbn_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int SW   = C + 2;
	localparam int SPW  = C + 1;
	localparam int AW_  = 2*C + 4;
	localparam int IW   = 2*C + 2;
	localparam int UW   = 2*C + 5;
	localparam int UNW  = UW + 1;
	localparam int HALF = UW / 2;
	localparam int HIW  = UW - HALF;
	localparam int CW   = UW + Q_FRAC + 1;

	logic signed [C-1:0] kx1, ky1, kx2, ky2, bx1, by1, bx2, by2;
	logic signed [C-1:0] xx1, yy1, xx2, yy2;
	logic signed [SW-1:0] dx, dy;
	logic [SPW-1:0] sx, sy;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [SPW-1:0] sx_s1, sy_s1;
	logic signed [AW_-1:0] karea_s1, karea_s2;
	logic [IW-1:0] inter_s2, inter_s3, inter_s4;
	logic signed [UNW-1:0] uni_s3;
	logic [HALF+THR_W-1:0] plo_s4;
	logic [HIW+THR_W-1:0] phi_s4;
	logic pos_s4, zero_s4, pos_s5, zero_s5, nz_s5;
	logic [CW-1:0] lhs_s5, rhs_s5;

	assign kx1 = krec[0*C +: C];
	assign ky1 = krec[1*C +: C];
	assign kx2 = krec[2*C +: C];
	assign ky2 = krec[3*C +: C];
	assign bx1 = box[0*C +: C];
	assign by1 = box[1*C +: C];
	assign bx2 = box[2*C +: C];
	assign by2 = box[3*C +: C];

	always_comb begin
		xx1 = (kx1 > bx1) ? kx1 : bx1;
		yy1 = (ky1 > by1) ? ky1 : by1;
		xx2 = (kx2 < bx2) ? kx2 : bx2;
		yy2 = (ky2 < by2) ? ky2 : by2;
		dx  = SW'(xx2) - SW'(xx1) + SW'(ONE_PIXEL);
		dy  = SW'(yy2) - SW'(yy1) + SW'(ONE_PIXEL);
		sx  = dx[SW-1] ? '0 : dx[SPW-1:0];
		sy  = dy[SW-1] ? '0 : dy[SPW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sx_s1    <= sx;
		sy_s1    <= sy;
		karea_s1 <= krec[4*C +: AW_];

		inter_s2 <= sx_s1 * sy_s1;
		karea_s2 <= karea_s1;

		uni_s3   <= UNW'(karea_s2) + UNW'(barea) - UNW'(inter_s2);
		inter_s3 <= inter_s2;

		// The union is split in two halves to keep each multiplier narrow.
		plo_s4   <= uni_s3[HALF-1:0] * thr;
		phi_s4   <= uni_s3[UW-1:HALF] * thr;
		pos_s4   <= !uni_s3[UNW-1] && (uni_s3 != '0);
		zero_s4  <= (uni_s3 == '0);
		inter_s4 <= inter_s3;

		rhs_s5  <= (CW'(phi_s4) << HALF) + CW'(plo_s4);
		lhs_s5  <= CW'(inter_s4) << Q_FRAC;
		pos_s5  <= pos_s4;
		zero_s5 <= zero_s4;
		nz_s5   <= (inter_s4 != '0);
	end

	always_comb begin
		stat.busy      = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
		stat.res_valid = v_s5;
		stat.res_sup   = zero_s5 ? nz_s5 : (pos_s5 && (lhs_s5 > rhs_s5));
	end
endmodule

>>> hdl/gbn_chk.sv
// Port-level checker for the box suppression block, bound to the top level.
`include "greedy_box_nms_macros.svh"

module gbn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	// A result that is not taken stays offered.
	`GBN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	// Each box is worked on alone, so no transfer follows directly.
	`GBN_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	// A full keep list never keeps the box.
	`GBN_ASSERT_NOW(a_full_not_kept, m_tvalid && m_tuser[1], !m_tuser[0])
	// A dropped box carries no keep slot.
	`GBN_ASSERT_NOW(a_rank_zero, m_tvalid && !m_tuser[0], m_tdata[21:13] == 9'd0)
endmodule

bind greedy_box_nms gbn_chk u_gbn_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
